[hdl/sbs_pkg.sv]
package sbs_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int PAD_WIDTH = 8;
	localparam logic [PAD_WIDTH-1:0] RADIUS_PAD_RESET = 8'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ_SET,
		ST_SQ_RUN,
		ST_SQ_ACC,
		ST_CMP,
		ST_SQRT_RUN,
		ST_DELTA,
		ST_MD_SET,
		ST_MD_RUN,
		ST_DIV_SET,
		ST_DIV_RUN,
		ST_APPLY,
		ST_RAD,
		ST_OUT
	} state_t;

endpackage

[hdl/streaming_bounding_sphere_core.sv]
// channel   dir  handshake                  payload
// s_*       in   s_tvalid / s_tready        tdata: x, y, z; tuser: first_point
// m_*       out  m_tvalid / m_tready        tdata: cx, cy, cz, radius; tuser: grew
// cfg_*     in   cfg_valid / cfg_ready      cfg_data: radius_pad
//
// one item at a time; a first point goes straight to the output register once that is free
// an inside point takes four shift-add squares: three axes and the radius (W = COORD_WIDTH)
// an outside point adds a W+2 step square root and, per axis, a W+2 step multiply
// and a 2W+4 step restoring divide
// the next item is taken while the last result waits in the output register
// arst_n clears the sphere to origin, radius zero, pad one
module streaming_bounding_sphere_core
	import sbs_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// x, y, z from bit 0 up, zero fill to bytes
	input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	// first_point
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// center_x, center_y, center_z, radius from bit 0 up
	output logic [((4*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
	// grew
	output logic m_tuser,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [PAD_WIDTH-1:0] cfg_data
);

	localparam int W = COORD_WIDTH;
	localparam int MW = W + 2;               // multiplier operand / root width
	localparam int PW = 2 * MW;              // product / squared distance width
	localparam int CW = $clog2(PW + 1);
	localparam int ODW = ((4*W+7)/8)*8;

	state_t state_q, state_d;

	logic [2:0][W-1:0] ctr_q;
	logic [W-1:0]      rad_q;
	logic [PAD_WIDTH-1:0] pad_q;
	logic [2:0][W:0]   diff_q;   // point minus center, signed
	logic [1:0]        k_q;
	logic [CW-1:0]     cnt_q;
	logic              grew_q;

	// shared shift-add multiplier
	logic [PW-1:0] mul_a_q;
	logic [MW-1:0] mul_b_q;
	logic [PW-1:0] prod_q;
	logic [PW-1:0] d2_q;

	// square root, two radicand bits per step
	logic [PW-1:0] sq_v_q;
	logic [MW+1:0] sq_rem_q;
	logic [MW-1:0] root_q;
	logic [MW+1:0] sq_cat;
	logic [MW+1:0] sq_trial;

	// restoring divider, quotient shifts into the numerator register
	logic [PW-1:0] div_n_q;
	logic [MW:0]   div_rem_q;
	logic [MW:0]   div_cat;
	logic [MW-1:0] delta_q;

	logic [ODW-1:0] out_data_q;
	logic           out_valid_q;
	logic           out_grew_q;

	logic [W:0]    mag_k;
	logic          last_cnt;
	logic [W+1:0]  c_ext;
	logic [W+1:0]  mv_ext;
	logic [W+1:0]  c_new;
	logic [MW:0]   nr;
	logic [2:0][W-1:0] pt_in;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pt_in[i] = s_tdata[i*W +: W];
		end
	end

	assign mag_k = diff_q[k_q][W] ? (~diff_q[k_q] + 1'b1) : diff_q[k_q];
	assign last_cnt = (cnt_q == CW'(MW - 1));
	assign sq_cat = {sq_rem_q[MW-1:0], sq_v_q[PW-1 -: 2]};
	assign sq_trial = {root_q, 2'b01};
	assign div_cat = {div_rem_q[MW-1:0], div_n_q[PW-1]};
	assign c_ext = {{2{ctr_q[k_q][W-1]}}, ctr_q[k_q]};
	assign mv_ext = {1'b0, div_n_q[W:0]};
	assign c_new = diff_q[k_q][W] ? (c_ext - mv_ext) : (c_ext + mv_ext);
	assign nr = {3'b000, rad_q} + {1'b0, delta_q} + {{(MW+1-PAD_WIDTH){1'b0}}, pad_q};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = s_tuser ? ST_OUT : ST_SQ_SET;
				end
			end
			ST_SQ_SET:   state_d = ST_SQ_RUN;
			ST_SQ_RUN:   if (last_cnt) state_d = ST_SQ_ACC;
			ST_SQ_ACC:   state_d = (k_q == 2'd3) ? ST_CMP : ST_SQ_SET;
			ST_CMP:      state_d = (d2_q > prod_q) ? ST_SQRT_RUN : ST_OUT;
			ST_SQRT_RUN: if (last_cnt) state_d = ST_DELTA;
			ST_DELTA:    state_d = ST_MD_SET;
			ST_MD_SET:   state_d = ST_MD_RUN;
			ST_MD_RUN:   if (last_cnt) state_d = ST_DIV_SET;
			ST_DIV_SET:  state_d = ST_DIV_RUN;
			ST_DIV_RUN:  if (cnt_q == CW'(PW - 1)) state_d = ST_APPLY;
			ST_APPLY:    state_d = (k_q == 2'd2) ? ST_RAD : ST_MD_SET;
			ST_RAD:      state_d = ST_OUT;
			ST_OUT:      if (!out_valid_q) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		cfg_ready = 1'b1;
		m_tvalid = out_valid_q;
		m_tdata = out_data_q;
		m_tuser = out_grew_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ctr_q <= '0;
			rad_q <= '0;
			pad_q <= RADIUS_PAD_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				pad_q <= cfg_data;
			end
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tuser) begin
						ctr_q <= pt_in;
						rad_q <= '0;
					end
				end
				ST_APPLY: ctr_q[k_q] <= c_new[W-1:0];
				ST_RAD:   rad_q <= (nr[MW:W] != '0) ? {W{1'b1}} : nr[W-1:0];
				ST_OUT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				grew_q <= 1'b0;
				k_q <= '0;
				d2_q <= '0;
				for (int i = 0; i < 3; i++) begin
					diff_q[i] <= {pt_in[i][W-1], pt_in[i]} - {ctr_q[i][W-1], ctr_q[i]};
				end
			end
			ST_SQ_SET: begin
				cnt_q <= '0;
				prod_q <= '0;
				if (k_q == 2'd3) begin
					mul_a_q <= PW'(rad_q);
					mul_b_q <= MW'(rad_q);
				end else begin
					mul_a_q <= PW'(mag_k);
					mul_b_q <= MW'(mag_k);
				end
			end
			ST_SQ_RUN, ST_MD_RUN: begin
				if (mul_b_q[0]) prod_q <= prod_q + mul_a_q;
				mul_a_q <= mul_a_q << 1;
				mul_b_q <= mul_b_q >> 1;
				cnt_q <= cnt_q + 1'b1;
			end
			ST_SQ_ACC: begin
				if (k_q != 2'd3) begin
					d2_q <= d2_q + prod_q;
					k_q <= k_q + 1'b1;
				end
			end
			ST_CMP: begin
				sq_v_q <= d2_q;
				sq_rem_q <= '0;
				root_q <= '0;
				cnt_q <= '0;
			end
			ST_SQRT_RUN: begin
				sq_v_q <= sq_v_q << 2;
				cnt_q <= cnt_q + 1'b1;
				if (sq_cat >= sq_trial) begin
					sq_rem_q <= sq_cat - sq_trial;
					root_q <= {root_q[MW-2:0], 1'b1};
				end else begin
					sq_rem_q <= sq_cat;
					root_q <= {root_q[MW-2:0], 1'b0};
				end
			end
			ST_DELTA: begin
				delta_q <= (root_q - MW'(rad_q)) >> 1;
				k_q <= '0;
			end
			ST_MD_SET: begin
				cnt_q <= '0;
				prod_q <= '0;
				mul_a_q <= PW'(mag_k);
				mul_b_q <= delta_q;
			end
			ST_DIV_SET: begin
				div_n_q <= prod_q;
				div_rem_q <= '0;
				cnt_q <= '0;
			end
			ST_DIV_RUN: begin
				cnt_q <= cnt_q + 1'b1;
				if (div_cat >= {1'b0, root_q}) begin
					div_rem_q <= div_cat - {1'b0, root_q};
					div_n_q <= {div_n_q[PW-2:0], 1'b1};
				end else begin
					div_rem_q <= div_cat;
					div_n_q <= {div_n_q[PW-2:0], 1'b0};
				end
			end
			ST_APPLY: k_q <= k_q + 1'b1;
			ST_RAD:   grew_q <= 1'b1;
			ST_OUT: begin
				if (!out_valid_q) begin
					out_data_q <= ODW'({rad_q, ctr_q[2], ctr_q[1], ctr_q[0]});
					out_grew_q <= grew_q;
				end
			end
			default: ;
		endcase
	end

endmodule

[hdl/sbs_checker.sv]
module sbs_checker
	import sbs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tuser))
		else $error("result dropped while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while busy");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> !m_tvalid)
		else $error("result repeated");

endmodule

bind streaming_bounding_sphere_core sbs_checker u_sbs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tuser(m_tuser)
);

[sim/tb_streaming_bounding_sphere_core.sv]
`timescale 1ns / 1ps

module tb_streaming_bounding_sphere_core;
	import sbs_pkg::*;

	localparam int CW = 32;
	localparam longint CYCLE_LIMIT = 6000000;
	localparam int DRAIN_CYCLES = 600;

	typedef struct {
		logic [CW-1:0] cx;
		logic [CW-1:0] cy;
		logic [CW-1:0] cz;
		logic [CW-1:0] rad;
		logic          grew;
	} sphere_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	// x, y, z from bit 0 up
	logic [3*CW-1:0] s_tdata;
	// first_point
	logic s_tuser;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// center_x, center_y, center_z, radius from bit 0 up
	logic [4*CW-1:0] m_tdata;
	// grew
	logic m_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [PAD_WIDTH-1:0] cfg_data;

	// model copy of the sphere and the pad register
	logic signed [CW-1:0] model_ctr [3];
	logic [CW-1:0]        model_rad;
	logic [PAD_WIDTH-1:0] model_pad;

	sphere_t pending_spheres[$];
	int      mismatches = 0;
	longint  cycles = 0;
	bit      quiet;
	int      stall_left = 0;

	streaming_bounding_sphere_core #(.COORD_WIDTH(CW)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, a few long ones; none at all in quiet phases
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 20);
		return $urandom_range(30, 150);
	endfunction

	// advance the sphere by one point and return what the block should emit
	function automatic sphere_t advance_sphere(logic [CW-1:0] px, logic [CW-1:0] py,
			logic [CW-1:0] pz, logic first);
		longint          diff [3];
		longint unsigned mag [3];
		logic [127:0]    d2, rr, wm, cand;
		longint unsigned root_v, delta, mv, nr;
		longint          c;
		logic [CW-1:0]   pt [3];
		sphere_t         s;
		pt[0] = px;
		pt[1] = py;
		pt[2] = pz;
		s.grew = 1'b0;
		if (first) begin
			for (int k = 0; k < 3; k++)
				model_ctr[k] = pt[k];
			model_rad = '0;
		end else begin
			d2 = '0;
			for (int k = 0; k < 3; k++) begin
				diff[k] = longint'($signed(pt[k])) - longint'(model_ctr[k]);
				mag[k] = diff[k] < 0 ? -diff[k] : diff[k];
				wm = mag[k];
				d2 = d2 + wm * wm;
			end
			rr = model_rad;
			rr = rr * rr;
			if (d2 > rr) begin
				// floor square root, bit by bit
				root_v = 0;
				for (int b = 63; b >= 0; b--) begin
					cand = root_v | (64'd1 << b);
					if (cand * cand <= d2)
						root_v = cand[63:0];
				end
				delta = (root_v - model_rad) >> 1;
				for (int k = 0; k < 3; k++) begin
					wm = mag[k];
					wm = (wm * delta) / root_v;
					mv = wm[63:0];
					c = longint'(model_ctr[k]);
					c = diff[k] < 0 ? c - longint'(mv) : c + longint'(mv);
					model_ctr[k] = c[CW-1:0];
				end
				nr = longint'(model_rad) + delta + model_pad;
				model_rad = nr > 64'hFFFF_FFFF ? '1 : nr[CW-1:0];
				s.grew = 1'b1;
			end
		end
		s.cx = model_ctr[0];
		s.cy = model_ctr[1];
		s.cz = model_ctr[2];
		s.rad = model_rad;
		return s;
	endfunction

	task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
		mismatches++;
	endtask

	// one point onto the slave side; valid stays high across back-to-back items
	task automatic send_point(logic [CW-1:0] px, logic [CW-1:0] py, logic [CW-1:0] pz,
			logic first);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {pz, py, px};
		s_tuser  <= first;
		do @(posedge clk); while (!s_tready);
		pending_spheres.push_back(advance_sphere(px, py, pz, first));
	endtask

	task automatic finish_stream();
		s_tvalid <= 1'b0;
		while (pending_spheres.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// pad register written only with the block idle
	task automatic write_pad(logic [PAD_WIDTH-1:0] val);
		finish_stream();
		cfg_valid <= 1'b1;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		model_pad = val;
	endtask

	// output side: random backpressure
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			stall_left <= pick_gap();
			m_tready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		sphere_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_spheres.size() == 0) begin
				report_mismatch("unexpected item", m_tdata[CW-1:0], '0);
			end else begin
				w = pending_spheres.pop_front();
				if (m_tdata[CW-1:0] !== w.cx)
					report_mismatch("center_x", m_tdata[CW-1:0], w.cx);
				if (m_tdata[2*CW-1:CW] !== w.cy)
					report_mismatch("center_y", m_tdata[2*CW-1:CW], w.cy);
				if (m_tdata[3*CW-1:2*CW] !== w.cz)
					report_mismatch("center_z", m_tdata[3*CW-1:2*CW], w.cz);
				if (m_tdata[4*CW-1:3*CW] !== w.rad)
					report_mismatch("radius", m_tdata[4*CW-1:3*CW], w.rad);
				if (m_tuser !== w.grew)
					report_mismatch("grew", CW'(m_tuser), CW'(w.grew));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// points before any first point, then first, coincident and surface points
	task automatic test_reset_sphere_and_surface();
		logic [CW-1:0] sx;
		send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
		send_point(32'h0003_0000, 32'hFFFC_0000, 32'h0000_8000, 1'b0);
		send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b1);
		send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0);
		send_point(32'h0011_0000, 32'h0002_0000, 32'h0003_0000, 1'b0);
		// exactly on the surface along x
		sx = model_ctr[0] - model_rad;
		send_point(sx, model_ctr[1], model_ctr[2], 1'b0);
		send_point(sx - 1, model_ctr[1], model_ctr[2], 1'b0);
	endtask

	// corner points of the coordinate range
	task automatic test_extremes();
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0);
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, 1'b0);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
	endtask

	function automatic logic [CW-1:0] near_coord(logic [CW-1:0] base, int shift);
		logic signed [CW-1:0] off;
		off = $signed($urandom()) >>> shift;
		return base + off;
	endfunction

	// point sets: a first point then a cloud around it, with some noise
	task automatic test_point_sets(int count);
		logic [CW-1:0] bx, by, bz;
		int left, shift, r;
		left = 0;
		shift = 0;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (left == 0 || r < 3) begin
				left = $urandom_range(1, 30);
				shift = $urandom_range(0, 31);
				bx = $urandom();
				by = $urandom();
				bz = $urandom();
				if ($urandom_range(0, 1))
					{bx, by, bz} = {bx >>> 4, by >>> 4, bz >>> 4};
				send_point(bx, by, bz, 1'b1);
			end else if (r < 8) begin
				send_point($urandom(), $urandom(), $urandom(), 1'($urandom_range(0, 1)));
			end else begin
				send_point(near_coord(bx, shift), near_coord(by, shift),
					near_coord(bz, shift), 1'b0);
			end
			left--;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		quiet = 1'b0;
		for (int k = 0; k < 3; k++)
			model_ctr[k] = '0;
		model_rad = '0;
		model_pad = RADIUS_PAD_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_sphere_and_surface();
		test_extremes();
		test_point_sets(380);
		write_pad(8'd0);
		test_reset_sphere_and_surface();
		test_point_sets(380);
		write_pad(8'hFF);
		test_extremes();
		quiet = 1'b1;
		test_point_sets(200);
		quiet = 1'b0;
		test_point_sets(180);
		write_pad(PAD_WIDTH'($urandom_range(2, 254)));
		test_point_sets(380);
		finish_stream();

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
